/* rtl/core/kth_prime_factor_finder_macros.svh */
// Assertion macros shared by the RTL.
`ifndef KTH_PRIME_FACTOR_FINDER_MACROS_SVH
`define KTH_PRIME_FACTOR_FINDER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define KPF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpf: implication check failed");

// Next-cycle implication
`define KPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpf: next-cycle check failed");

`else

`define KPF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KPF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/kpf_pkg.sv */
package kpf_pkg;

  // Port field widths
  localparam int unsigned NUMBER_W = 16;
  localparam int unsigned RANK_W   = 8;
  localparam int unsigned FACTOR_W = 16;

  // Microprogram addresses
  typedef enum logic [3:0] {
    S_WAIT      = 4'd0,
    S_SKIP      = 4'd1,
    S_TEST      = 4'd2,
    S_DIV_GO    = 4'd3,
    S_DIV_WAIT  = 4'd4,
    S_CHECK     = 4'd5,
    S_COUNT     = 4'd6,
    S_DIV_OUT   = 4'd7,
    S_NEXT      = 4'd8,
    S_TAIL      = 4'd9,
    S_EMIT      = 4'd10,
    S_RETURN    = 4'd11
  } step_t;

  // Datapath actions
  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_DIV_GO,
    A_COUNT,
    A_DIV_OUT,
    A_NEXT_CAND,
    A_TAIL,
    A_EMIT
  } act_t;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_TRIVIAL,
    C_SQ_GT_N,
    C_DIV_BUSY,
    C_REM_NZ,
    C_HIT_NOW
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{act: A_NONE, cond: C_NEVER, target: S_WAIT};
    case (s)
      S_WAIT:     w = '{act: A_LOAD,      cond: C_NO_INPUT, target: S_WAIT};
      S_SKIP:     w = '{act: A_NONE,      cond: C_TRIVIAL,  target: S_EMIT};
      S_TEST:     w = '{act: A_NONE,      cond: C_SQ_GT_N,  target: S_TAIL};
      S_DIV_GO:   w = '{act: A_DIV_GO,    cond: C_NEVER,    target: S_WAIT};
      S_DIV_WAIT: w = '{act: A_NONE,      cond: C_DIV_BUSY, target: S_DIV_WAIT};
      S_CHECK:    w = '{act: A_NONE,      cond: C_REM_NZ,   target: S_NEXT};
      S_COUNT:    w = '{act: A_COUNT,     cond: C_HIT_NOW,  target: S_EMIT};
      S_DIV_OUT:  w = '{act: A_DIV_OUT,   cond: C_ALWAYS,   target: S_DIV_GO};
      S_NEXT:     w = '{act: A_NEXT_CAND, cond: C_ALWAYS,   target: S_TEST};
      S_TAIL:     w = '{act: A_TAIL,      cond: C_NEVER,    target: S_WAIT};
      S_EMIT:     w = '{act: A_EMIT,      cond: C_NEVER,    target: S_WAIT};
      S_RETURN:   w = '{act: A_NONE,      cond: C_ALWAYS,   target: S_WAIT};
      default:    w = '{act: A_NONE,      cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/kpf_div.sv */
module kpf_div #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH:0]   rem;
  logic [WIDTH-1:0] quo;
  logic [CntW-1:0]  cnt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // One restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem[WIDTH-1:0], quo[WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(WIDTH);
    end else if (busy) begin
      cnt  <= cnt - CntW'(1);
      busy <= (cnt != CntW'(1));
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff;
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[WIDTH-1:0];

endmodule

/* rtl/core/kth_prime_factor_finder.sv */
// k-th prime factor finder, trial division.
// Input channel (in_valid/in_ready): number and rank (one-based k). Output channel
// (out_valid/out_ready): found and factor; one result transaction per input, in order.
// Factors are counted with multiplicity in ascending order; found = 0 and factor = 0
// when rank is zero, number is below 2, or there are fewer than rank factors.
// A small microprogram steps a datapath holding the remaining value, the candidate,
// its square and the factor count. Each trial n % cand goes through a shared
// restoring divider, one quotient bit per cycle.
// Candidates run up to the square root of what remains.
// One item is worked at a time; in_ready is high only while the sequencer waits.
// The result sits in an output register, so the next item is taken while a
// finished result waits; if the receiver stalls a second result, the sequencer
// holds at its emit step until the register frees.
// Reset (synchronous) returns the sequencer to its wait step and empties the output.
`include "kth_prime_factor_finder_macros.svh"

module kth_prime_factor_finder #(
  parameter int unsigned NUM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kpf_pkg::NUMBER_W-1:0]  number,
  input  logic [kpf_pkg::RANK_W-1:0]    rank,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [kpf_pkg::FACTOR_W-1:0]  factor
);

  import kpf_pkg::*;

  localparam int unsigned SqW = NUM_WIDTH + 2;

  step_t                step;
  step_t                step_next;
  uword_t               ctrl;

  logic [NUM_WIDTH-1:0] n;
  logic [NUM_WIDTH-1:0] cand;
  logic [SqW-1:0]       sq;
  logic [RANK_W-1:0]    k;
  logic [RANK_W-1:0]    count;
  logic [RANK_W-1:0]    count_inc;
  logic                 hit;
  logic [NUM_WIDTH-1:0] prime;

  logic                 div_go;
  logic                 div_busy;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;

  logic                 cond_true;
  logic                 out_free;
  logic                 emit;

  // Shared divider for n / cand
  kpf_div #(
    .WIDTH(NUM_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (n),
    .divisor  (cand),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Control word decode
  always_comb begin
    ctrl      = ucode(step);
    count_inc = count + RANK_W'(1);
    out_free  = !out_valid || out_ready;
    in_ready  = (ctrl.act == A_LOAD);
    div_go    = (ctrl.act == A_DIV_GO);
    emit      = (ctrl.act == A_EMIT) && out_free;
  end

  // Branch condition select
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_INPUT: cond_true = !in_valid;
      C_TRIVIAL:  cond_true = (k == '0) || (n[NUM_WIDTH-1:1] == '0);
      C_SQ_GT_N:  cond_true = (sq > SqW'(n));
      C_DIV_BUSY: cond_true = div_busy;
      C_REM_NZ:   cond_true = (div_rem != '0);
      C_HIT_NOW:  cond_true = (count_inc == k);
      default:    cond_true = 1'b0;
    endcase
  end

  // Next step: jump, hold at emit while the output is full, or fall through
  always_comb begin
    if (ctrl.act == A_EMIT && !out_free) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = ctrl.target;
    end else begin
      step_next = step_t'(4'(step + 4'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      case (ctrl.act)
        A_LOAD: begin
          if (in_valid) begin
            n     <= NUM_WIDTH'(number);
            k     <= rank;
            count <= '0;
            cand  <= NUM_WIDTH'(2);
            sq    <= SqW'(4);
            hit   <= 1'b0;
          end
        end
        A_COUNT: begin
          count <= count_inc;
          if (count_inc == k) begin
            hit   <= 1'b1;
            prime <= cand;
          end
        end
        A_DIV_OUT: n <= div_quo;
        A_NEXT_CAND: begin
          // (c+1)^2 = c^2 + 2c + 1
          cand <= cand + NUM_WIDTH'(1);
          sq   <= sq + SqW'({cand, 1'b1});
        end
        A_TAIL: begin
          // leftover above one is the last prime factor
          if (n[NUM_WIDTH-1:1] != '0 && count_inc == k) begin
            count <= count_inc;
            hit   <= 1'b1;
            prime <= n;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found  <= hit;
      factor <= hit ? FACTOR_W'(prime) : '0;
    end
  end

  // Checks
  `KPF_ASSERT_IMP(a_no_restart, clk, rst, div_go, !div_busy)
  `KPF_ASSERT_NEXT(a_div_runs, clk, rst, div_go, div_busy)
  `KPF_ASSERT_IMP(a_hit_count, clk, rst, hit, count == k)
  `KPF_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !found, factor == '0)

endmodule

/* tb/kth_prime_factor_finder_tb.sv */
`timescale 1ns / 100ps

module kth_prime_factor_finder_tb;

  import kpf_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned SETTLE_CYCLES = 100;

  // One input transaction, with a flag to hold it back until the block drains
  typedef struct {
    logic [NUMBER_W-1:0] num;
    logic [RANK_W-1:0]   k;
    bit                  drain;
  } factor_query_t;

  // Expected result, with the query kept for reporting
  typedef struct {
    logic                found;
    logic [FACTOR_W-1:0] factor;
    logic [NUMBER_W-1:0] num;
    logic [RANK_W-1:0]   k;
  } factor_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NUMBER_W-1:0] number = '0;
  logic [RANK_W-1:0]   rank = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [FACTOR_W-1:0] factor;

  factor_query_t  queries[$];
  factor_answer_t pending_answers[$];
  factor_query_t  next_query;
  factor_answer_t want;

  bit          in_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  bit          rx_toggle = 1'b0;

  kth_prime_factor_finder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .number    (number),
    .rank      (rank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .factor    (factor)
  );

  // Trial division over the 16-bit working width; factors counted with multiplicity
  function automatic factor_answer_t kth_factor(input logic [NUMBER_W-1:0] num,
                                                input logic [RANK_W-1:0] k);
    factor_answer_t ans;
    int unsigned    rest;
    int unsigned    cand;
    int unsigned    seen;
    bit             hit;
    int unsigned    prime;
    rest  = num;
    seen  = 0;
    hit   = 1'b0;
    prime = 0;
    if (k != 0 && rest >= 2) begin
      for (cand = 2; cand * cand <= rest && !hit; cand++) begin
        while (!hit && rest % cand == 0) begin
          seen++;
          if (seen == k) begin
            hit   = 1'b1;
            prime = cand;
          end else begin
            rest = rest / cand;
          end
        end
      end
      // leftover is 1 or one prime above the square root
      if (!hit && rest > 1) begin
        seen++;
        if (seen == k) begin
          hit   = 1'b1;
          prime = rest;
        end
      end
    end
    ans.found  = hit;
    ans.factor = hit ? prime[FACTOR_W-1:0] : '0;
    ans.num    = num;
    ans.k      = k;
    return ans;
  endfunction

  task automatic add_query(input int unsigned num, input int unsigned k, input bit drain);
    factor_query_t q;
    q.num   = num[NUMBER_W-1:0];
    q.k     = k[RANK_W-1:0];
    q.drain = drain;
    queries.push_back(q);
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10)
      $display("%s", msg);
    fail_count++;
  endtask

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus build-up, then reset release
  initial begin
    int unsigned small_primes[12];
    int unsigned big_primes[6];
    int unsigned prod;
    int unsigned p;
    int unsigned k;
    int unsigned steps;
    small_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 251, 257, 3};
    big_primes   = '{65521, 65519, 65497, 32749, 16381, 65479};

    // Directed: extremes and edge cases
    add_query(0, 1, 1'b0);        // number zero
    add_query(1, 1, 1'b0);        // number one
    add_query(2, 0, 1'b0);        // rank zero
    add_query(2, 1, 1'b0);
    add_query(2, 2, 1'b0);        // too few factors
    add_query(65535, 4, 1'b0);    // 3*5*17*257, tail prime
    add_query(65535, 5, 1'b0);
    add_query(65535, 0, 1'b0);
    add_query(65521, 1, 1'b0);    // largest 16-bit prime
    add_query(65521, 255, 1'b0);
    add_query(32768, 15, 1'b0);   // 2^15
    add_query(32768, 16, 1'b0);
    add_query(65534, 4, 1'b0);
    add_query(4, 2, 1'b0);        // square of a prime
    add_query(49, 2, 1'b0);
    add_query(6, 2, 1'b0);
    add_query(12, 3, 1'b0);
    add_query(65025, 6, 1'b0);    // 3^2 * 5^2 * 17^2
    add_query(255, 255, 1'b0);
    add_query(65535, 170, 1'b0);
    add_query(21845, 85, 1'b1);   // held until the block has drained

    // Random part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        4, 5: begin
          prod  = 1;
          steps = $urandom_range(1, 12);
          for (int j = 0; j < steps; j++) begin
            p = small_primes[$urandom_range(0, 11)];
            if (prod * p <= 65535)
              prod = prod * p;
          end
        end
        6: prod = (1 << $urandom_range(1, 15)) * $urandom_range(1, 3);
        7: prod = big_primes[$urandom_range(0, 5)];
        8: prod = $urandom_range(0, 15);
        default: prod = $urandom_range(0, 65535);
      endcase
      if (prod > 65535)
        prod = 65535;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: k = $urandom_range(1, 5);
        5, 6, 7: k = $urandom_range(1, 17);
        default: k = $urandom_range(0, 255);
      endcase
      add_query(prod, k, $urandom_range(0, 19) == 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Sender: bursts with random gaps, holds a transaction until accepted
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (queries.size() != 0 &&
                   !(queries[0].drain && pending_answers.size() != 0)) begin
        next_query = queries.pop_front();
        number   <= next_query.num;
        rank     <= next_query.k;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: runs of always-ready, random, stalled and alternating ready
  always @(negedge clk) begin
    bit ready_next;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(1, 64);
    end
    rx_left   = rx_left - 1;
    rx_toggle = ~rx_toggle;
    case (rx_mode)
      0: ready_next = 1'b1;
      1: ready_next = 1'($urandom_range(0, 1));
      2: ready_next = 1'b0;
      default: ready_next = rx_toggle;
    endcase
    out_ready <= ready_next;
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        pending_answers.push_back(kth_factor(number, rank));
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          note_failure($sformatf("unexpected result: found=%0d factor=%0d", found, factor));
        end else begin
          want = pending_answers.pop_front();
          if (found !== want.found || factor !== want.factor)
            note_failure($sformatf(
              "mismatch number=%0d rank=%0d: exp found=%0d factor=%0d got found=%0d factor=%0d",
              want.num, want.k, want.found, want.factor, found, factor));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // End of run
  initial begin
    @(negedge rst);
    while (queries.size() != 0 || in_valid)
      @(posedge clk);
    while (pending_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_answers.size()));
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
